// File: rtl/xor_checksum_pcx_rle_decoder_assert.svh
// assertion macros used by the decoder back end (xcrle_back)
// they sample on clk_i and are disabled while rst_ni is low
`ifndef XOR_CHECKSUM_PCX_RLE_DECODER_ASSERT_SVH
`define XOR_CHECKSUM_PCX_RLE_DECODER_ASSERT_SVH

// same-cycle implication
`define XCRLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XCRLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/xcrle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xcrle_pkg;

  // header layout
  localparam logic [7:0] HdrBytes  = 8'd128;
  localparam logic [7:0] PosBpp    = 8'd3;
  localparam logic [7:0] PosPlanes = 8'd65;
  localparam logic [7:0] PosExt0   = 8'd4;
  localparam logic [7:0] BppOk     = 8'd8;
  localparam logic [7:0] PlanesOk  = 8'd1;

  // run-length coding
  localparam logic [7:0] RunMark = 8'hC0;
  localparam logic [7:0] RunMask = 8'h3F;

  // result kinds
  localparam logic KindPixel  = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_CKSUM   = 3'd1,
    ST_FORMAT  = 3'd2,
    ST_OVERRUN = 3'd3,
    ST_SHORT   = 3'd4,
    ST_TRUNC   = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  pixel_value;
    logic [31:0] pixel_index;
    logic [2:0]  status_code;
    logic        run_end;
  } out_t;

  // one classified input byte: a run of pixels and/or a status
  typedef struct packed {
    logic [5:0]  cnt;
    logic [7:0]  val;
    logic [31:0] idx;
    logic        has_stat;
    status_e     code;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/xor_checksum_pcx_rle_decoder.sv
// path: results pass the command queue, the work register and the output register
// throughput: one byte per cycle in unless full; one result per cycle out while popped;
//   a run of n pixels takes n results and the two-entry command queue then stalls input
// reset: rst_ni is asynchronous and active low; it clears entry state, the queue,
//   the result valid flag and both configuration registers to zero
`timescale 1ns / 1ps
`default_nettype none

module xor_checksum_pcx_rle_decoder (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // byte input
  input  wire logic              push,
  output logic                   full,
  input  wire xcrle_pkg::in_t    in_data_i,
  // result output
  output logic                   empty,
  input  wire logic              pop,
  output xcrle_pkg::out_t        out_data_o,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [7:0] xor_key_q, checksum_seed_q;
  logic       cfg_wr;

  logic            in_valid;
  logic            cmd_valid, q_full, q_nonempty, q_pop;
  xcrle_pkg::cmd_t cmd, q_head;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {24'd0, paddr[2] ? checksum_seed_q : xor_key_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_key_q       <= '0;
      checksum_seed_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        checksum_seed_q <= pwdata[7:0];
      end else begin
        xor_key_q <= pwdata[7:0];
      end
    end
  end

  assign full     = q_full;
  assign in_valid = push && !q_full;

  xcrle_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_data_i       (in_data_i),
    .xor_key_i       (xor_key_q),
    .checksum_seed_i (checksum_seed_q),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  xcrle_cmd_q u_cmd_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (cmd_valid),
    .wr_data_i  (cmd),
    .rd_i       (q_pop),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .rd_data_o  (q_head)
  );

  xcrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_nonempty),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/xcrle_front.sv
`timescale 1ns / 1ps
`default_nettype none

module xcrle_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire xcrle_pkg::in_t   in_data_i,
  input  wire logic [7:0]       xor_key_i,
  input  wire logic [7:0]       checksum_seed_i,
  output logic                  cmd_valid_o,
  output xcrle_pkg::cmd_t       cmd_o
);

  logic [7:0]          pos_q, pos_d;
  logic [7:0]          ck_q, ck_d;
  logic [15:0]         ext_q [4];
  logic [15:0]         ext_d [4];
  logic [7:0]          bpp_q, bpp_d;
  logic [7:0]          planes_q, planes_d;
  logic [31:0]         tgt_q, tgt_d;
  logic [31:0]         pd_q, pd_d;
  logic                pend_q, pend_d;
  logic [5:0]          plen_q, plen_d;
  xcrle_pkg::status_e  err_q, err_d;

  logic        in_hdr;
  logic [7:0]  ck_base;
  logic [7:0]  dbyte;
  logic [16:0] span_x, span_y;
  logic [33:0] area;
  logic [31:0] area_sat;
  logic        fmt_bad;
  logic [32:0] run_sum;

  assign in_hdr  = pos_q < xcrle_pkg::HdrBytes;
  assign ck_base = (pos_q == 8'd0) ? checksum_seed_i : ck_q;
  assign dbyte   = in_data_i.raw_byte ^ xor_key_i;

  // header check and image size
  assign fmt_bad = (bpp_q != xcrle_pkg::BppOk) || (planes_q != xcrle_pkg::PlanesOk) ||
                   (ext_q[2] < ext_q[0]) || (ext_q[3] < ext_q[1]);
  assign span_x   = {1'b0, ext_q[2]} - {1'b0, ext_q[0]} + 17'd1;
  assign span_y   = {1'b0, ext_q[3]} - {1'b0, ext_q[1]} + 17'd1;
  assign area     = span_x * span_y;
  assign area_sat = (area[33:32] != 2'b00) ? '1 : area[31:0];

  assign run_sum = {1'b0, pd_q} + {27'd0, (dbyte[5:0] & xcrle_pkg::RunMask[5:0])};

  // classify the byte and update entry state
  always_comb begin
    pos_d    = pos_q;
    ck_d     = ck_q;
    ext_d    = ext_q;
    bpp_d    = bpp_q;
    planes_d = planes_q;
    tgt_d    = tgt_q;
    pd_d     = pd_q;
    pend_d   = pend_q;
    plen_d   = plen_q;
    err_d    = err_q;

    cmd_o          = '0;
    cmd_o.val      = dbyte;
    cmd_o.idx      = pd_q;
    cmd_o.code     = xcrle_pkg::ST_OK;
    cmd_valid_o    = 1'b0;

    if (in_valid_i) begin
      ck_d = ck_base - in_data_i.raw_byte;

      if (in_hdr) begin
        if (pos_q == xcrle_pkg::PosBpp) bpp_d = dbyte;
        if (pos_q == xcrle_pkg::PosPlanes) planes_d = dbyte;
        for (int k = 0; k < 4; k++) begin
          if (pos_q == xcrle_pkg::PosExt0 + 8'(2 * k)) ext_d[k][7:0] = dbyte;
          if (pos_q == xcrle_pkg::PosExt0 + 8'(2 * k + 1)) ext_d[k][15:8] = dbyte;
        end
        if (pos_q == xcrle_pkg::HdrBytes - 8'd1) begin
          if (fmt_bad) begin
            err_d = xcrle_pkg::ST_FORMAT;
            tgt_d = '0;
          end else begin
            tgt_d = area_sat;
          end
        end
        pos_d = pos_q + 8'd1;
      end else if (err_q == xcrle_pkg::ST_OK) begin
        if (pend_q) begin
          cmd_o.cnt = plen_q;
          pd_d      = pd_q + {26'd0, plen_q};
          pend_d    = 1'b0;
          plen_d    = '0;
        end else if (pd_q < tgt_q) begin
          if (dbyte >= xcrle_pkg::RunMark) begin
            if (run_sum > {1'b0, tgt_q}) begin
              err_d = xcrle_pkg::ST_OVERRUN;
            end else begin
              pend_d = 1'b1;
              plen_d = dbyte[5:0] & xcrle_pkg::RunMask[5:0];
            end
          end else begin
            cmd_o.cnt = 6'd1;
            pd_d      = pd_q + 32'd1;
          end
        end
      end

      // end of entry: status with priority, then back to the reset state
      if (in_data_i.final_byte) begin
        cmd_o.has_stat = 1'b1;
        if (ck_d != 8'd0) begin
          cmd_o.code = xcrle_pkg::ST_CKSUM;
        end else if (err_d != xcrle_pkg::ST_OK) begin
          cmd_o.code = err_d;
        end else if (pos_d < xcrle_pkg::HdrBytes) begin
          cmd_o.code = xcrle_pkg::ST_TRUNC;
        end else if (pend_d) begin
          cmd_o.code = xcrle_pkg::ST_OVERRUN;
        end else if (pd_d < tgt_d) begin
          cmd_o.code = xcrle_pkg::ST_SHORT;
        end else begin
          cmd_o.code = xcrle_pkg::ST_OK;
        end
        pos_d    = '0;
        ext_d    = '{default: '0};
        bpp_d    = '0;
        planes_d = '0;
        tgt_d    = '0;
        pd_d     = '0;
        pend_d   = 1'b0;
        plen_d   = '0;
        err_d    = xcrle_pkg::ST_OK;
      end

      cmd_valid_o = (cmd_o.cnt != 6'd0) || cmd_o.has_stat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      ck_q     <= '0;
      ext_q    <= '{default: '0};
      bpp_q    <= '0;
      planes_q <= '0;
      tgt_q    <= '0;
      pd_q     <= '0;
      pend_q   <= 1'b0;
      plen_q   <= '0;
      err_q    <= xcrle_pkg::ST_OK;
    end else begin
      pos_q    <= pos_d;
      ck_q     <= ck_d;
      ext_q    <= ext_d;
      bpp_q    <= bpp_d;
      planes_q <= planes_d;
      tgt_q    <= tgt_d;
      pd_q     <= pd_d;
      pend_q   <= pend_d;
      plen_q   <= plen_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/xcrle_cmd_q.sv
`timescale 1ns / 1ps
`default_nettype none

module xcrle_cmd_q (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire xcrle_pkg::cmd_t  wr_data_i,
  input  wire logic             rd_i,
  output logic                  full_o,
  output logic                  nonempty_o,
  output xcrle_pkg::cmd_t       rd_data_o
);

  xcrle_pkg::cmd_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o     = cnt_q == 2'd2;
  assign nonempty_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && nonempty_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/xcrle_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "xor_checksum_pcx_rle_decoder_assert.svh"

module xcrle_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire xcrle_pkg::cmd_t  cmd_i,
  output logic                  cmd_pop_o,
  input  wire logic             pop,
  output logic                  empty,
  output xcrle_pkg::out_t       out_data_o
);

  logic [5:0]          w_cnt_q, w_cnt_d;
  logic                w_stat_q, w_stat_d;
  logic [7:0]          w_val_q, w_val_d;
  logic [31:0]         w_idx_q, w_idx_d;
  xcrle_pkg::status_e  w_code_q, w_code_d;

  xcrle_pkg::out_t out_q, res;
  logic            out_vld_q, out_vld_d;

  logic busy, last, slot_free, emit, load;

  assign busy      = (w_cnt_q != 6'd0) || w_stat_q;
  assign last      = (w_cnt_q == 6'd1 && !w_stat_q) || (w_cnt_q == 6'd0 && w_stat_q);
  assign slot_free = !out_vld_q || pop;
  assign emit      = busy && slot_free;
  assign load      = cmd_valid_i && (!busy || (emit && last));
  assign cmd_pop_o = load;

  // next result from the work register
  always_comb begin
    res = '0;
    if (w_cnt_q != 6'd0) begin
      res.item_kind   = xcrle_pkg::KindPixel;
      res.pixel_value = w_val_q;
      res.pixel_index = w_idx_q;
      res.status_code = xcrle_pkg::ST_OK;
    end else begin
      res.item_kind   = xcrle_pkg::KindStatus;
      res.pixel_index = w_idx_q;
      res.status_code = w_code_q;
    end
    res.run_end = last;
  end

  // work register: count down the run, then the status
  always_comb begin
    w_cnt_d  = w_cnt_q;
    w_stat_d = w_stat_q;
    w_val_d  = w_val_q;
    w_idx_d  = w_idx_q;
    w_code_d = w_code_q;
    if (load) begin
      w_cnt_d  = cmd_i.cnt;
      w_stat_d = cmd_i.has_stat;
      w_val_d  = cmd_i.val;
      w_idx_d  = cmd_i.idx;
      w_code_d = cmd_i.code;
    end else if (emit) begin
      if (w_cnt_q != 6'd0) begin
        w_cnt_d = w_cnt_q - 6'd1;
        w_idx_d = w_idx_q + 32'd1;
      end else begin
        w_stat_d = 1'b0;
      end
    end
  end

  assign out_vld_d = emit ? 1'b1 : (pop ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_cnt_q   <= '0;
      w_stat_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      w_cnt_q   <= w_cnt_d;
      w_stat_q  <= w_stat_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    w_val_q  <= w_val_d;
    w_idx_q  <= w_idx_d;
    w_code_q <= w_code_d;
    if (emit) begin
      out_q <= res;
    end
  end

  assign empty      = !out_vld_q;
  assign out_data_o = out_q;

  `XCRLE_ASSERT_NOW(a_status_ends, out_vld_q && out_q.item_kind == xcrle_pkg::KindStatus, out_q.run_end, "status result without run_end")
  `XCRLE_ASSERT_NOW(a_pixel_no_code, out_vld_q && out_q.item_kind == xcrle_pkg::KindPixel, out_q.status_code == xcrle_pkg::ST_OK, "pixel result carries a status code")
  `XCRLE_ASSERT_NXT(a_index_steps, emit && w_cnt_q != 6'd0 && !load, w_idx_q == $past(w_idx_q) + 32'd1, "pixel index did not advance")

endmodule

`default_nettype wire
